// File: src/pltw_pkg.sv
// Package: link word packer constants and the serializer load struct.
package pltw_pkg;

	localparam int WORD_BITS    = 80;
	localparam int PADDED_BYTES = 16;
	localparam int PLD_BITS     = 80;
	localparam int CFG_W        = 7;

	localparam int WORD_BYTES = (WORD_BITS + 7) / 8;
	localparam int SER_BITS   = WORD_BYTES * 8;
	localparam int PAD_BYTES  = (PADDED_BYTES > WORD_BYTES) ? PADDED_BYTES : WORD_BYTES;
	localparam int IDX_W      = $clog2(PAD_BYTES);
	localparam int FILL_W     = $clog2(WORD_BITS);
	localparam int SUM_W      = FILL_W + 1;
	localparam int WIDE_BITS  = WORD_BITS + PLD_BITS;

	localparam logic CFG_PAYLOAD_WIDTH = 1'b0;
	localparam logic CFG_PAD_ENABLE    = 1'b1;

	localparam logic [CFG_W-1:0] PAYLOAD_WIDTH_RST = CFG_W'(76);

	typedef struct packed {
		logic                load;
		logic [SER_BITS-1:0] word;
		logic [IDX_W-1:0]    last_idx;
	} ser_load_t;

endpackage

// File: src/pltw_ser.sv
// Byte serializer: shifts one link word out a byte per transfer, then zero pad bytes.
module pltw_ser (
	input  logic                clk,
	input  logic                arst_n,
	input  pltw_pkg::ser_load_t ld,
	output logic                free,
	output logic                byte_valid,
	input  logic                byte_stall,
	output logic [7:0]          data_byte,
	output logic                last_byte
);

	logic                          busy_q;
	logic [pltw_pkg::IDX_W-1:0]    idx_q;
	logic [pltw_pkg::IDX_W-1:0]    last_q;
	logic [pltw_pkg::SER_BITS-1:0] word_q;
	logic                          xfer;
	logic                          done;

	assign xfer = busy_q && !byte_stall;
	assign done = (idx_q == last_q);
	assign free = !busy_q || (xfer && done);

	assign byte_valid = busy_q;
	assign data_byte  = word_q[7:0];
	assign last_byte  = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			last_q <= '0;
		end else if (ld.load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			last_q <= ld.last_idx;
		end else if (xfer) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + pltw_pkg::IDX_W'(1);
			end
		end
	end

	// zeros shift in, so pad bytes come out as zero
	always_ff @(posedge clk) begin
		if (ld.load) begin
			word_q <= ld.word;
		end else if (xfer) begin
			word_q <= {8'h00, word_q[pltw_pkg::SER_BITS-1:8]};
		end
	end

endmodule

// File: src/payload_to_link_word_packer.sv
// Top level: payload to link word packer (bit gearbox into link words, byte output).
//
// Each pack item is taken into an input register and merged from there into the pending
// link word. An item that completes a word (or a flush with a non-zero fill) hands the
// word to the byte serializer, which sends WORD_BYTES bytes (10), or PAD_BYTES (16) with
// padding on, one byte per transfer; such an item waits in the input register while the
// previous word is still draining, so a stream of word-completing items is held to the
// pace of the serializer's single byte output. The user must write configuration
// between frames only; the block itself does not enforce it.
module payload_to_link_word_packer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [pltw_pkg::CFG_W-1:0] cfg_data,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic                      action,
	input  logic [63:0]               payload_low,
	input  logic [15:0]               payload_high,
	output logic                      byte_valid,
	input  logic                      byte_stall,
	output logic [7:0]                data_byte,
	output logic                      last_byte
);

	logic [pltw_pkg::CFG_W-1:0]     pw_q;
	logic                           pad_q;
	logic                           vld_s1;
	logic                           action_s1;
	logic [pltw_pkg::PLD_BITS-1:0]  pld_s1;
	logic [pltw_pkg::WORD_BITS-1:0] word_q;
	logic [pltw_pkg::FILL_W-1:0]    fill_q;

	logic [pltw_pkg::SUM_W-1:0]     w_sat;
	logic [pltw_pkg::SUM_W-1:0]     sum;
	logic [pltw_pkg::WIDE_BITS-1:0] shifted;
	logic [pltw_pkg::WORD_BITS-1:0] merged;
	logic [pltw_pkg::WORD_BITS-1:0] carry;
	logic [pltw_pkg::WORD_BITS-1:0] send_w;
	logic                           send;
	logic                           commit;
	logic                           ser_free;
	pltw_pkg::ser_load_t            ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q  <= pltw_pkg::PAYLOAD_WIDTH_RST;
			pad_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pltw_pkg::CFG_PAYLOAD_WIDTH: pw_q  <= cfg_data;
				pltw_pkg::CFG_PAD_ENABLE:    pad_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign w_sat = (32'(pw_q) > pltw_pkg::WORD_BITS) ? pltw_pkg::SUM_W'(pltw_pkg::WORD_BITS)
	                                                 : pltw_pkg::SUM_W'(pw_q);
	assign sum     = pltw_pkg::SUM_W'(fill_q) + w_sat;
	assign shifted = pltw_pkg::WIDE_BITS'(pld_s1) << fill_q;
	assign merged  = word_q | shifted[pltw_pkg::WORD_BITS-1:0];
	assign carry   = pltw_pkg::WORD_BITS'(shifted >> pltw_pkg::WORD_BITS);

	assign send   = action_s1 ? (fill_q != '0)
	                          : (32'(sum) >= pltw_pkg::WORD_BITS);
	assign send_w = action_s1 ? word_q : merged;
	assign commit = vld_s1 && (!send || ser_free);

	assign item_stall = vld_s1 && !commit;

	assign ld.load     = commit && send;
	assign ld.word     = pltw_pkg::SER_BITS'(send_w);
	assign ld.last_idx = pad_q ? pltw_pkg::IDX_W'(pltw_pkg::PAD_BYTES - 1)
	                           : pltw_pkg::IDX_W'(pltw_pkg::WORD_BYTES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			vld_s1 <= 1'b1;
		end else if (commit) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1 <= action;
			pld_s1    <= {payload_high, payload_low};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			fill_q <= '0;
		end else if (commit) begin
			if (action_s1) begin
				word_q <= '0;
				fill_q <= '0;
			end else if (send) begin
				word_q <= carry;
				fill_q <= pltw_pkg::FILL_W'(sum - pltw_pkg::SUM_W'(pltw_pkg::WORD_BITS));
			end else begin
				word_q <= merged;
				fill_q <= pltw_pkg::FILL_W'(sum);
			end
		end
	end

	pltw_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (ld),
		.free       (ser_free),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte)
	);

endmodule

// File: src/pltw_chk.sv
// Port checker for the link word packer, bound to the top level.
module pltw_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       item_stall,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] data_byte,
	input logic       last_byte
);

	// a stalled byte stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid)
		else $error("byte dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> $stable(data_byte) && $stable(last_byte))
		else $error("stalled byte changed");

	// bytes of one item go out without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && !last_byte |=> byte_valid)
		else $error("gap inside a word transfer");

	// the input only waits on a word still draining
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> byte_valid)
		else $error("input stalled with idle serializer");

endmodule

bind payload_to_link_word_packer pltw_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_stall (item_stall),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.data_byte  (data_byte),
	.last_byte  (last_byte)
);

// File: tb/tb.sv
// Testbench for payload_to_link_word_packer: directed and random packing checked byte by byte.
module tb;

	localparam logic ACT_PACK  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;
	localparam int   SETTLE    = 24;
	localparam int   PHASES    = 9;
	localparam int   PHASE_LEN = 36;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} link_byte_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic                          cfg_index;
	logic [pltw_pkg::CFG_W-1:0]    cfg_data;
	logic                          item_valid;
	logic                          item_stall;
	logic                          action;
	logic [63:0]                   payload_low;
	logic [15:0]                   payload_high;
	logic                          byte_valid;
	logic                          byte_stall;
	logic [7:0]                    data_byte;
	logic                          last_byte;

	// packer state as predicted
	logic [pltw_pkg::WORD_BITS-1:0] pend_word;
	int unsigned                    pend_fill;
	int unsigned                    cur_width;
	bit                             cur_pad;
	link_byte_t                     expected_bytes[$];

	int errors;
	int n_packs;
	int n_flushes;
	int n_words;
	int n_bytes;
	int burst_left;
	bit gaps_on;

	payload_to_link_word_packer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.payload_low  (payload_low),
		.payload_high (payload_high),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	// receiver stall pattern: free runs, random stalls, and a 5-of-8 duty stall
	initial begin : stall_gen
		int mode;
		int len;
		int k;
		byte_stall = 1'b0;
		k = 0;
		forever begin
			mode = $urandom_range(0, 2);
			len  = $urandom_range(20, 120);
			repeat (len) begin
				@(negedge clk);
				k++;
				case (mode)
					0: byte_stall <= 1'b0;
					1: byte_stall <= ($urandom_range(0, 3) == 0);
					default: byte_stall <= ((k % 8) < 5);
				endcase
			end
		end
	end

	task automatic queue_word(input logic [pltw_pkg::WORD_BITS-1:0] w);
		int total;
		link_byte_t b;
		total = (cur_pad && pltw_pkg::PADDED_BYTES > pltw_pkg::WORD_BYTES)
		        ? pltw_pkg::PADDED_BYTES : pltw_pkg::WORD_BYTES;
		for (int i = 0; i < total; i++) begin
			b.data = (i < pltw_pkg::WORD_BYTES) ? w[8*i +: 8] : 8'h00;
			b.last = (i == total - 1);
			expected_bytes = {expected_bytes, b};
		end
		n_words++;
	endtask

	task automatic pack_into_word(input logic act, input logic [pltw_pkg::PLD_BITS-1:0] pld);
		logic [pltw_pkg::WORD_BITS+pltw_pkg::PLD_BITS-1:0] wide;
		int unsigned w;
		if (act == ACT_FLUSH) begin
			if (pend_fill > 0)
				queue_word(pend_word);
			pend_word = '0;
			pend_fill = 0;
			n_flushes++;
		end else begin
			w = (cur_width > pltw_pkg::WORD_BITS) ? pltw_pkg::WORD_BITS : cur_width;
			wide = {{pltw_pkg::WORD_BITS{1'b0}}, pld} << pend_fill;
			pend_word |= wide[pltw_pkg::WORD_BITS-1:0];
			if (pend_fill + w < pltw_pkg::WORD_BITS) begin
				pend_fill += w;
			end else begin
				queue_word(pend_word);
				pend_word = wide[pltw_pkg::WORD_BITS+pltw_pkg::PLD_BITS-1:pltw_pkg::WORD_BITS];
				pend_fill = pend_fill + w - pltw_pkg::WORD_BITS;
			end
			n_packs++;
		end
	endtask

	task automatic idle_cycles(input int n);
		@(negedge clk);
		item_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_item(input logic act, input logic [pltw_pkg::PLD_BITS-1:0] pld);
		@(negedge clk);
		item_valid   <= 1'b1;
		action       <= act;
		payload_low  <= pld[63:0];
		payload_high <= pld[79:64];
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pack_into_word(act, pld);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if (gaps_on)
				idle_cycles($urandom_range(1, 6));
			burst_left = $urandom_range(0, 10);
		end
	endtask

	// hold off until every predicted byte is out, then let the block settle
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [pltw_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == pltw_pkg::CFG_PAYLOAD_WIDTH)
			cur_width = 32'(value);
		else
			cur_pad = value[0];
	endtask

	task automatic set_config(input int width, input bit pad);
		write_cfg(pltw_pkg::CFG_PAYLOAD_WIDTH, pltw_pkg::CFG_W'(width));
		write_cfg(pltw_pkg::CFG_PAD_ENABLE, pltw_pkg::CFG_W'(pad));
	endtask

	function automatic logic [pltw_pkg::PLD_BITS-1:0] rand_payload(input int width);
		logic [pltw_pkg::PLD_BITS-1:0] p;
		int sel;
		p[31:0]  = $urandom;
		p[63:32] = $urandom;
		p[79:64] = 16'($urandom);
		sel = $urandom_range(0, 9);
		if (sel <= 4) begin
			if (width < pltw_pkg::PLD_BITS)
				p &= (80'd1 << width) - 80'd1;
		end else if (sel == 8) begin
			p = '1;
		end else if (sel == 9) begin
			p = ($urandom_range(0, 1) == 0) ? '0 : (80'd1 << $urandom_range(0, 79));
		end
		return p;
	endfunction

	always @(posedge clk) begin : byte_check
		link_byte_t exp_b;
		if (arst_n && byte_valid && !byte_stall) begin
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer data_byte=%h last_byte=%b",
					$time, data_byte, last_byte);
			end else begin
				exp_b = expected_bytes.pop_front();
				n_bytes++;
				if (data_byte !== exp_b.data) begin
					errors++;
					$display("%0t: data_byte expected %h actual %h",
						$time, exp_b.data, data_byte);
				end
				if (last_byte !== exp_b.last) begin
					errors++;
					$display("%0t: last_byte expected %b actual %b",
						$time, exp_b.last, last_byte);
				end
			end
		end
	end

	task automatic test_reset_values();
		send_item(ACT_PACK, '1);
		send_item(ACT_PACK, '0);
		send_item(ACT_PACK, rand_payload(76));
		send_item(ACT_FLUSH, '0);
		drain();
	endtask

	task automatic test_field_extremes();
		set_config(80, 0);
		send_item(ACT_PACK, '1);
		send_item(ACT_PACK, '0);
		send_item(ACT_PACK, {1'b1, 78'd0, 1'b1});
		send_item(ACT_FLUSH, '1);
		drain();
		// bits above the width land in the word as they are
		set_config(1, 0);
		send_item(ACT_PACK, '1);
		send_item(ACT_PACK, '1);
		send_item(ACT_PACK, 80'h5);
		send_item(ACT_FLUSH, '1);
		drain();
		// carried bits are dropped by a flush at zero fill
		set_config(40, 0);
		send_item(ACT_PACK, '1);
		send_item(ACT_PACK, '1);
		send_item(ACT_FLUSH, '0);
		send_item(ACT_PACK, '0);
		send_item(ACT_PACK, '0);
		send_item(ACT_FLUSH, '0);
		drain();
	endtask

	task automatic test_width_limits_and_padding();
		set_config(0, 0);
		send_item(ACT_PACK, '1);
		send_item(ACT_PACK, rand_payload(80));
		send_item(ACT_FLUSH, '0);
		drain();
		set_config(127, 1);
		send_item(ACT_PACK, rand_payload(80));
		send_item(ACT_PACK, '1);
		send_item(ACT_FLUSH, '0);
		drain();
	endtask

	task automatic test_random_traffic();
		int width;
		bit pad;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin width = 1; pad = 1'b1; end
				1: begin width = 80; pad = 1'b0; end
				2: begin width = $urandom_range(81, 127); pad = 1'($urandom_range(0, 1)); end
				default: begin
					width = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 80);
					pad = 1'($urandom_range(0, 1));
				end
			endcase
			set_config(width, pad);
			gaps_on = (ph % 3 != 0);
			for (int i = 0; i < PHASE_LEN; i++) begin
				if (ph == 4 && i == PHASE_LEN / 2)
					drain();
				if ($urandom_range(0, 11) == 0)
					send_item(ACT_FLUSH, rand_payload(80));
				else
					send_item(ACT_PACK, rand_payload(width));
			end
			send_item(ACT_FLUSH, '0);
			drain();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = pltw_pkg::CFG_PAYLOAD_WIDTH;
		cfg_data     = '0;
		item_valid   = 1'b0;
		action       = ACT_PACK;
		payload_low  = '0;
		payload_high = '0;
		pend_word    = '0;
		pend_fill    = 0;
		cur_width    = 76;
		cur_pad      = 1'b0;
		errors       = 0;
		n_packs      = 0;
		n_flushes    = 0;
		n_words      = 0;
		n_bytes      = 0;
		burst_left   = 0;
		gaps_on      = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_field_extremes();
		test_width_limits_and_padding();
		test_random_traffic();

		$display("covered %0d packs and %0d flushes, %0d link words, %0d bytes compared",
			n_packs, n_flushes, n_words, n_bytes);
		$display("widths 0, 1, 80 and above the word size, with padding on and off");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
